[rtl/core/frf_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// frf_pkg
// Shared types, codes and geometry helpers for the frame rotate/flip engine.
// ----------------------------------------------------------------------------
package frf_pkg;

  localparam int unsigned DIM_W      = 11;  // frame dimensions, 1..1024
  localparam int unsigned IDX_W      = 10;  // row and column indexes, 0..1023
  localparam int unsigned PIX_W      = 48;  // packed Y, Cb, Cr
  localparam int unsigned MODE_W     = 3;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 11;
  localparam int unsigned QDEPTH     = 4;
  localparam int unsigned QPTR_W     = 2;
  localparam int unsigned QCNT_W     = 3;

  localparam logic [DIM_W-1:0] DIM_LIMIT = 11'd1024;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_MODE           = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_OUT_HEIGHT = 2'd3;

  // Command codes.
  localparam logic CMD_STORE = 1'b0;
  localparam logic CMD_FETCH = 1'b1;

  typedef enum logic [MODE_W-1:0] {
    MODE_ROT_RIGHT = 3'd0,
    MODE_ROT_LEFT  = 3'd1,
    MODE_ROT_180   = 3'd2,
    MODE_MIRROR_H  = 3'd3,
    MODE_MIRROR_V  = 3'd4
  } mode_e;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [DIM_W-1:0]  frame_width;
    logic [DIM_W-1:0]  frame_height;
    logic [DIM_W-1:0]  max_out_height;
  } cfg_t;

  // Derived frame geometry, held in registers next to the configuration.
  typedef struct packed {
    mode_e            mode;
    logic [DIM_W-1:0] ow;    // output width
    logic [DIM_W-1:0] oh;    // output height
    logic [DIM_W-1:0] off;   // crop offset for the 90-degree modes
    logic [DIM_W-1:0] hm1;   // source height - 1
    logic [DIM_W-1:0] wm1;   // source width - 1
    logic [DIM_W-1:0] wmo;   // source width - offset - 1
    logic [DIM_W-1:0] owm1;  // output width - 1
    logic [DIM_W-1:0] ohm1;  // output height - 1
  } geom_t;

  localparam cfg_t CFG_RESET = '{
    mode:           3'd0,
    frame_width:    11'd640,
    frame_height:   11'd480,
    max_out_height: 11'd576
  };

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] hi);
    logic [DIM_W-1:0] res;
    if (v == '0) begin
      res = {{(DIM_W-1){1'b0}}, 1'b1};
    end else if (v > hi) begin
      res = hi;
    end else begin
      res = v;
    end
    return res;
  endfunction

  function automatic geom_t calc_geom(input cfg_t cfg,
                                      input logic [DIM_W-1:0] lim_w,
                                      input logic [DIM_W-1:0] lim_h);
    geom_t            g;
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
    logic [DIM_W-1:0] mh;
    logic [DIM_W-1:0] one;
    one = {{(DIM_W-1){1'b0}}, 1'b1};
    w   = clamp_dim(cfg.frame_width, lim_w);
    h   = clamp_dim(cfg.frame_height, lim_h);
    mh  = clamp_dim(cfg.max_out_height, DIM_LIMIT);
    g.mode = (cfg.mode > MODE_MIRROR_V) ? MODE_MIRROR_V : mode_e'(cfg.mode);
    g.off  = '0;
    if (g.mode == MODE_ROT_RIGHT || g.mode == MODE_ROT_LEFT) begin
      g.ow = h;
      if (w < mh) begin
        g.oh = w;
      end else begin
        g.off = (w - mh) >> 1;
        g.oh  = mh;
      end
    end else begin
      g.ow = w;
      g.oh = h;
    end
    g.hm1  = h - one;
    g.wm1  = w - one;
    g.wmo  = w - g.off - one;
    g.owm1 = g.ow - one;
    g.ohm1 = g.oh - one;
    return g;
  endfunction

endpackage
`default_nettype wire

[rtl/core/frame_rotate_flip_engine.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// frame_rotate_flip_engine
// Frame store that takes pixels in raster order and returns them rotated by
// 90, -90 or 180 degrees, or mirrored horizontally or vertically.
// ----------------------------------------------------------------------------
// A command is taken at every clock edge where start is high and busy is low,
// so the block sustains one store or one fetch per clock: each command is a
// single access to the single-port frame memory, and that one port sets the
// rate. A fetch goes through the front stage, queue and result registers and
// shows its pixel for exactly one cycle, marked by valid_o; a store gives no
// result. The receiver cannot hold results off, and since the back end drains
// the operation queue in every cycle, busy stays low in normal operation.
// Stores and fetches are carried out in the order they were taken, so a fetch
// always sees every store taken before it. The frame memory has no reset and
// no clearing pass: fetching a location that was never stored returns
// whatever the memory holds. Configuration writes take effect at once and
// restart both the store walk and the fetch walk at pixel zero; they are to
// be issued only while no fetch result is outstanding.
// ----------------------------------------------------------------------------
module frame_rotate_flip_engine #(
  parameter int unsigned MAX_COLUMNS = 1024,
  parameter int unsigned MAX_ROWS    = 1024
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // Command channel
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic                           command_i,
  input  wire logic [frf_pkg::PIX_W-1:0]      pixel_value_i,
  // Configuration write port
  input  wire logic                           cfg_we_i,
  input  wire logic [frf_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [frf_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // Result channel
  output logic                                valid_o,
  output logic [frf_pkg::PIX_W-1:0]           out_pixel_o,
  output logic                                last_o,
  output logic [frf_pkg::DIM_W-1:0]           out_width_o,
  output logic [frf_pkg::DIM_W-1:0]           out_height_o
);

  // Address width of the frame memory, row stride MAX_COLUMNS.
  localparam int unsigned AW = $clog2(MAX_COLUMNS * MAX_ROWS);
  // Queue entry: fetch flag, last flag, pixel, address.
  localparam int unsigned EW = 2 + frf_pkg::PIX_W + AW;

  logic           push, space, q_valid, pop;
  logic [EW-1:0]  push_data, q_data;
  frf_pkg::geom_t geom;

  // Front: configuration, geometry, raster walks and address generation.
  frf_front #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS),
    .AW          (AW),
    .EW          (EW)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .busy_o        (busy),
    .command_i     (command_i),
    .pixel_value_i (pixel_value_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .space_i       (space),
    .push_o        (push),
    .push_data_o   (push_data),
    .geom_o        (geom)
  );

  // Operation queue between the two halves.
  frf_queue #(
    .W (EW)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_data),
    .space_o (space),
    .valid_o (q_valid),
    .data_o  (q_data),
    .pop_i   (pop)
  );

  // Back: frame memory access and result registers.
  frf_back #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS),
    .AW          (AW),
    .EW          (EW)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .op_valid_i   (q_valid),
    .op_data_i    (q_data),
    .pop_o        (pop),
    .geom_i       (geom),
    .valid_o      (valid_o),
    .out_pixel_o  (out_pixel_o),
    .last_o       (last_o),
    .out_width_o  (out_width_o),
    .out_height_o (out_height_o)
  );

endmodule
`default_nettype wire

[rtl/core/frf_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// frf_front
// Holds configuration and geometry, steps the raster counters and turns each
// command into a frame-store address pushed into the operation queue.
// ----------------------------------------------------------------------------
module frf_front #(
  parameter int unsigned MAX_COLUMNS = 1024,
  parameter int unsigned MAX_ROWS    = 1024,
  parameter int unsigned AW          = 20,
  parameter int unsigned EW          = 70
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start_i,
  output logic                                   busy_o,
  input  wire logic                              command_i,
  input  wire logic [frf_pkg::PIX_W-1:0]         pixel_value_i,
  input  wire logic                              cfg_we_i,
  input  wire logic [frf_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [frf_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  wire logic                              space_i,
  output logic                                   push_o,
  output logic [EW-1:0]                          push_data_o,
  output frf_pkg::geom_t                         geom_o
);

  localparam logic [frf_pkg::DIM_W-1:0] LIM_W =
    frf_pkg::DIM_W'((MAX_COLUMNS < 1024) ? MAX_COLUMNS : 1024);
  localparam logic [frf_pkg::DIM_W-1:0] LIM_H =
    frf_pkg::DIM_W'((MAX_ROWS < 1024) ? MAX_ROWS : 1024);

  frf_pkg::cfg_t  cfg_d, cfg_q;
  frf_pkg::geom_t geom_q;
  logic           accept;

  logic [frf_pkg::IDX_W-1:0] wr_c_d, wr_c_q, wr_r_d, wr_r_q;
  logic [frf_pkg::IDX_W-1:0] rd_x_d, rd_x_q, rd_y_d, rd_y_q;

  logic [frf_pkg::DIM_W-1:0] x_ext, y_ext, row_full, col_full;
  logic                      last_d;

  logic                       st_valid_q;
  logic                       st_fetch_q;
  logic                       st_last_q;
  logic [frf_pkg::IDX_W-1:0]  st_row_q, st_col_q;
  logic [frf_pkg::PIX_W-1:0]  st_pix_q;
  logic [AW-1:0]              addr;

  assign busy_o = ~space_i;
  assign accept = start_i & ~busy_o;
  assign geom_o = geom_q;

  // Configuration writes; every write restarts both raster walks.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        frf_pkg::CFG_MODE:           cfg_d.mode           = cfg_data_i[frf_pkg::MODE_W-1:0];
        frf_pkg::CFG_FRAME_WIDTH:    cfg_d.frame_width    = cfg_data_i;
        frf_pkg::CFG_FRAME_HEIGHT:   cfg_d.frame_height   = cfg_data_i;
        frf_pkg::CFG_MAX_OUT_HEIGHT: cfg_d.max_out_height = cfg_data_i;
        default:                     cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q  <= frf_pkg::CFG_RESET;
      geom_q <= frf_pkg::calc_geom(frf_pkg::CFG_RESET, LIM_W, LIM_H);
    end else begin
      cfg_q  <= cfg_d;
      geom_q <= frf_pkg::calc_geom(cfg_d, LIM_W, LIM_H);
    end
  end

  // Source position of the next fetch.
  assign x_ext = {1'b0, rd_x_q};
  assign y_ext = {1'b0, rd_y_q};

  always_comb begin
    unique case (geom_q.mode)
      frf_pkg::MODE_ROT_RIGHT: begin
        row_full = geom_q.hm1 - x_ext;
        col_full = geom_q.off + y_ext;
      end
      frf_pkg::MODE_ROT_LEFT: begin
        row_full = x_ext;
        col_full = geom_q.wmo - y_ext;
      end
      frf_pkg::MODE_ROT_180: begin
        row_full = geom_q.hm1 - y_ext;
        col_full = geom_q.wm1 - x_ext;
      end
      frf_pkg::MODE_MIRROR_H: begin
        row_full = y_ext;
        col_full = geom_q.wm1 - x_ext;
      end
      default: begin
        row_full = geom_q.hm1 - y_ext;
        col_full = x_ext;
      end
    endcase
  end

  assign last_d = (x_ext == geom_q.owm1) && (y_ext == geom_q.ohm1);

  // Raster counters for the store walk and the fetch walk.
  always_comb begin
    wr_c_d = wr_c_q;
    wr_r_d = wr_r_q;
    rd_x_d = rd_x_q;
    rd_y_d = rd_y_q;
    if (cfg_we_i) begin
      wr_c_d = '0;
      wr_r_d = '0;
      rd_x_d = '0;
      rd_y_d = '0;
    end else if (accept && command_i == frf_pkg::CMD_STORE) begin
      if ({1'b0, wr_c_q} == geom_q.wm1) begin
        wr_c_d = '0;
        wr_r_d = ({1'b0, wr_r_q} == geom_q.hm1) ? '0 : wr_r_q + 1'b1;
      end else begin
        wr_c_d = wr_c_q + 1'b1;
      end
    end else if (accept) begin
      if (x_ext == geom_q.owm1) begin
        rd_x_d = '0;
        rd_y_d = (y_ext == geom_q.ohm1) ? '0 : rd_y_q + 1'b1;
      end else begin
        rd_x_d = rd_x_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_c_q     <= '0;
      wr_r_q     <= '0;
      rd_x_q     <= '0;
      rd_y_q     <= '0;
      st_valid_q <= 1'b0;
    end else begin
      wr_c_q     <= wr_c_d;
      wr_r_q     <= wr_r_d;
      rd_x_q     <= rd_x_d;
      rd_y_q     <= rd_y_d;
      st_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      st_fetch_q <= command_i;
      st_pix_q   <= pixel_value_i;
      if (command_i == frf_pkg::CMD_STORE) begin
        st_row_q  <= wr_r_q;
        st_col_q  <= wr_c_q;
        st_last_q <= 1'b0;
      end else begin
        st_row_q  <= row_full[frf_pkg::IDX_W-1:0];
        st_col_q  <= col_full[frf_pkg::IDX_W-1:0];
        st_last_q <= last_d;
      end
    end
  end

  // Row stride is the column capacity of the store.
  assign addr        = AW'(st_row_q) * AW'(MAX_COLUMNS) + AW'(st_col_q);
  assign push_o      = st_valid_q;
  assign push_data_o = {st_fetch_q, st_last_q, st_pix_q, addr};

endmodule
`default_nettype wire

[rtl/core/frf_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// frf_queue
// Short first-in first-out queue between the front and back parts.
// ----------------------------------------------------------------------------
module frf_queue #(
  parameter int unsigned W = 70
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  input  wire logic [W-1:0] data_i,
  output logic              space_o,
  output logic              valid_o,
  output logic [W-1:0]      data_o,
  input  wire logic         pop_i
);

  logic [W-1:0]                 entries_q [frf_pkg::QDEPTH];
  logic [frf_pkg::QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [frf_pkg::QCNT_W-1:0]   count_q;
  logic                         do_pop;

  assign valid_o = (count_q != '0);
  assign data_o  = entries_q[rd_ptr_q];
  assign do_pop  = pop_i & valid_o;
  // Keep one slot free for the item that sits in the front stage.
  assign space_o = count_q < frf_pkg::QCNT_W'(frf_pkg::QDEPTH - 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      priority if (push_i && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (!push_i && do_pop) begin
        count_q <= count_q - 1'b1;
      end else begin
        count_q <= count_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= data_i;
    end
  end

endmodule
`default_nettype wire

[rtl/core/frf_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// frf_back
// Carries out queued store and fetch operations on the frame memory and
// presents each fetched pixel for one cycle.
// ----------------------------------------------------------------------------
module frf_back #(
  parameter int unsigned MAX_COLUMNS = 1024,
  parameter int unsigned MAX_ROWS    = 1024,
  parameter int unsigned AW          = 20,
  parameter int unsigned EW          = 70
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       op_valid_i,
  input  wire logic [EW-1:0]              op_data_i,
  output logic                            pop_o,
  input  wire frf_pkg::geom_t             geom_i,
  output logic                            valid_o,
  output logic [frf_pkg::PIX_W-1:0]       out_pixel_o,
  output logic                            last_o,
  output logic [frf_pkg::DIM_W-1:0]       out_width_o,
  output logic [frf_pkg::DIM_W-1:0]       out_height_o
);

  localparam int unsigned DEPTH = MAX_COLUMNS * MAX_ROWS;

  logic [frf_pkg::PIX_W-1:0] mem [DEPTH];

  logic                      op_fetch, op_last;
  logic [frf_pkg::PIX_W-1:0] op_pix;
  logic [AW-1:0]             op_addr;
  logic                      do_fetch;

  logic                      valid_q, last_q;
  logic [frf_pkg::PIX_W-1:0] rdata_q;
  logic [frf_pkg::DIM_W-1:0] ow_q, oh_q;

  assign {op_fetch, op_last, op_pix, op_addr} = op_data_i;

  // The back end never stalls: it takes the queue head in every cycle.
  assign pop_o    = op_valid_i;
  assign do_fetch = op_valid_i && (op_fetch == frf_pkg::CMD_FETCH);

  always_ff @(posedge clk_i) begin
    if (op_valid_i && op_fetch == frf_pkg::CMD_STORE) begin
      mem[op_addr] <= op_pix;
    end
    if (do_fetch) begin
      rdata_q <= mem[op_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= do_fetch;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_fetch) begin
      last_q <= op_last;
      ow_q   <= geom_i.ow;
      oh_q   <= geom_i.oh;
    end
  end

  assign valid_o      = valid_q;
  assign out_pixel_o  = rdata_q;
  assign last_o       = last_q;
  assign out_width_o  = ow_q;
  assign out_height_o = oh_q;

endmodule
`default_nettype wire

[rtl/core/frf_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// frf_checker
// Port-level checks on the frame rotate/flip engine, bound to its top level.
// ----------------------------------------------------------------------------
module frf_checker (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           start,
  input wire logic                           busy,
  input wire logic                           command_i,
  input wire logic                           valid_o,
  input wire logic [frf_pkg::DIM_W-1:0]      out_width_o,
  input wire logic [frf_pkg::DIM_W-1:0]      out_height_o
);

  logic fetch_xfer;
  assign fetch_xfer = start && !busy && (command_i == frf_pkg::CMD_FETCH);

  // Every fetch transfer yields its result, marked by valid_o.
  a_fetch_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fetch_xfer |-> ##3 valid_o)
    else $error("fetch transfer without result three cycles later");

  // No result appears without a matching fetch transfer.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(fetch_xfer, 3))
    else $error("result without a matching fetch transfer");

  // Reported frame sizes stay in the legal range.
  a_size_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (out_width_o != '0) && (out_width_o <= frf_pkg::DIM_LIMIT) &&
                (out_height_o != '0) && (out_height_o <= frf_pkg::DIM_LIMIT))
    else $error("output frame size out of range");

  // Back-to-back results belong to the same geometry.
  a_size_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && $past(valid_o) |-> $stable(out_width_o) && $stable(out_height_o))
    else $error("output frame size changed between consecutive results");

endmodule

bind frame_rotate_flip_engine frf_checker u_frf_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .command_i    (command_i),
  .valid_o      (valid_o),
  .out_width_o  (out_width_o),
  .out_height_o (out_height_o)
);
`default_nettype wire
